/* hdl/csv_tok_pkg.sv */
package csv_tok_pkg;

    localparam int ROW_COUNT_BITS_DEF = 32;
    localparam int COLUMN_COUNT_BITS_DEF = 16;

    localparam int CHAR_BITS = 16;
    localparam int FIELD_LEN_BITS = 21;
    localparam int MAX_ROWS_BITS = 32;
    localparam int ROW_OUT_BITS = 32;
    localparam int COL_OUT_BITS = 16;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [CHAR_BITS-1:0] CH_QUOTE = 16'h0022;
    localparam logic [CHAR_BITS-1:0] CH_CR = 16'h000D;
    localparam logic [CHAR_BITS-1:0] CH_LF = 16'h000A;

    localparam logic [FIELD_LEN_BITS-1:0] FIELD_LEN_MAX = '1;

    localparam logic [CHAR_BITS-1:0] SEPARATOR_RST = 16'd44;
    localparam logic [FIELD_LEN_BITS-1:0] MAX_FIELD_CHARS_RST = 21'h100000;
    localparam logic [MAX_ROWS_BITS-1:0] MAX_ROWS_RST = '1;

    typedef enum logic [1:0] {
        ACT_CHAR = 2'd0,
        ACT_EOI = 2'd1,
        ACT_RESTART = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        KIND_CHAR = 3'd0,
        KIND_FIELD_END = 3'd1,
        KIND_ROW_END = 3'd2,
        KIND_TOO_LONG = 3'd3,
        KIND_UNCLOSED = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        REG_SEPARATOR = 2'd0,
        REG_MAX_FIELD_CHARS = 2'd1,
        REG_MAX_ROWS = 2'd2
    } t_reg_index;

endpackage

/* hdl/csv_stream_tokenizer_core.sv */
// Channel   Dir  Handshake              tdata (low bit first)                  tuser
// s (char)  in   i_s_tvalid/o_s_tready  char_in[15:0]                          action[1:0]
// m (token) out  o_m_tvalid/i_m_tready  data_char, row_number, column_number   kind[2:0]
// cfg       in   APB psel/penable       separator, max_field_chars, max_rows   -
//
// One character per cycle while tokens are taken: the parser state and the token
// register update on the transfer, so a token appears in the next cycle.
// The token register frees in the cycle it is taken, so input flows while the
// output side keeps tready high; when it stalls with a token held, input stalls.
// Synchronous active-low reset clears parser state and loads register defaults.
module csv_stream_tokenizer_core #(
    parameter int ROW_COUNT_BITS = csv_tok_pkg::ROW_COUNT_BITS_DEF,
    parameter int COLUMN_COUNT_BITS = csv_tok_pkg::COLUMN_COUNT_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // char_in[15:0]
    input  logic [csv_tok_pkg::CHAR_BITS-1:0]      i_s_tdata,
    // action[1:0]
    input  logic [1:0]                             i_s_tuser,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // data_char[15:0], row_number[47:16], column_number[63:48]
    output logic [63:0]                            o_m_tdata,
    // kind[2:0]
    output logic [2:0]                             o_m_tuser,
    input  logic                                   i_psel,
    input  logic                                   i_penable,
    input  logic                                   i_pwrite,
    input  logic [csv_tok_pkg::APB_ADDR_BITS-1:0]  i_paddr,
    input  logic [csv_tok_pkg::APB_DATA_BITS-1:0]  i_pwdata,
    output logic [csv_tok_pkg::APB_DATA_BITS-1:0]  o_prdata,
    output logic                                   o_pready
);
    import csv_tok_pkg::*;

    localparam int CMP_BITS = (ROW_COUNT_BITS > MAX_ROWS_BITS - 1) ?
                              ROW_COUNT_BITS : MAX_ROWS_BITS - 1;

    logic [CHAR_BITS-1:0]         r_separator;
    logic [FIELD_LEN_BITS-1:0]    r_max_field_chars;
    logic [MAX_ROWS_BITS-1:0]     r_max_rows;

    logic                         r_in_quotes, n_in_quotes;
    logic                         r_pending_quote, n_pending_quote;
    logic                         r_skip_lf, n_skip_lf;
    logic [FIELD_LEN_BITS-1:0]    r_field_len, n_field_len;
    logic [COLUMN_COUNT_BITS-1:0] r_col_count, n_col_count;
    logic [ROW_COUNT_BITS-1:0]    r_row_count, n_row_count;
    logic                         r_stopped, n_stopped;

    logic                         r_m_valid;
    t_kind                        r_kind;
    logic [CHAR_BITS-1:0]         r_data_char;
    logic [ROW_OUT_BITS-1:0]      r_row_out;
    logic [COL_OUT_BITS-1:0]      r_col_out;

    logic                         s_acc;
    logic                         cfg_wr;
    logic [1:0]                   cfg_idx;
    logic                         emit;
    t_kind                        emit_kind;
    logic [CHAR_BITS-1:0]         emit_char;

    function automatic logic f_limit(input logic [ROW_COUNT_BITS-1:0] rc);
        logic [CMP_BITS-1:0] rc_ext;
        logic [CMP_BITS-1:0] lim_ext;
        rc_ext = CMP_BITS'(rc);
        lim_ext = CMP_BITS'(r_max_rows[MAX_ROWS_BITS-2:0]);
        return !r_max_rows[MAX_ROWS_BITS-1] && (rc_ext >= lim_ext);
    endfunction

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign s_acc = i_s_tvalid && o_s_tready;

    // configuration port
    assign o_pready = 1'b1;
    assign cfg_idx = i_paddr[3:2];
    assign cfg_wr = i_psel && i_penable && i_pwrite && o_pready;

    always_comb begin
        case (cfg_idx)
            REG_SEPARATOR:       o_prdata = APB_DATA_BITS'(r_separator);
            REG_MAX_FIELD_CHARS: o_prdata = APB_DATA_BITS'(r_max_field_chars);
            REG_MAX_ROWS:        o_prdata = r_max_rows;
            default:             o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_separator <= SEPARATOR_RST;
            r_max_field_chars <= MAX_FIELD_CHARS_RST;
            r_max_rows <= MAX_ROWS_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SEPARATOR:       r_separator <= i_pwdata[CHAR_BITS-1:0];
                REG_MAX_FIELD_CHARS: r_max_field_chars <= i_pwdata[FIELD_LEN_BITS-1:0];
                REG_MAX_ROWS:        r_max_rows <= i_pwdata;
                default: ;
            endcase
        end
    end

    // parser next state
    always_comb begin
        logic                      do_unq;
        logic                      do_append;
        logic                      do_row_end;
        logic                      halt;
        logic [FIELD_LEN_BITS-1:0] len_inc;
        logic [CHAR_BITS-1:0]      ch;

        n_in_quotes = r_in_quotes;
        n_pending_quote = r_pending_quote;
        n_skip_lf = r_skip_lf;
        n_field_len = r_field_len;
        n_col_count = r_col_count;
        n_row_count = r_row_count;
        n_stopped = r_stopped;
        emit = 1'b0;
        emit_kind = KIND_CHAR;
        emit_char = '0;
        do_unq = 1'b0;
        do_append = 1'b0;
        do_row_end = 1'b0;
        halt = r_stopped || f_limit(r_row_count);
        ch = i_s_tdata;
        len_inc = (r_field_len != FIELD_LEN_MAX) ? r_field_len + 1'b1 : r_field_len;

        if (s_acc) begin
            case (t_action'(i_s_tuser))
                ACT_RESTART: begin
                    n_in_quotes = 1'b0;
                    n_pending_quote = 1'b0;
                    n_skip_lf = 1'b0;
                    n_field_len = '0;
                    n_col_count = '0;
                    n_row_count = '0;
                    n_stopped = (r_max_rows == '0);
                end
                ACT_EOI: begin
                    n_stopped = halt;
                    if (!halt) begin
                        n_skip_lf = 1'b0;
                        n_pending_quote = 1'b0;
                        n_in_quotes = r_in_quotes && !r_pending_quote;
                        if (r_in_quotes && !r_pending_quote) begin
                            n_stopped = 1'b1;
                            emit = 1'b1;
                            emit_kind = KIND_UNCLOSED;
                        end else if (r_col_count != '0 || r_field_len != '0) begin
                            do_row_end = 1'b1;
                        end
                    end
                end
                ACT_CHAR: begin
                    n_stopped = halt;
                    if (!halt) begin
                        n_skip_lf = 1'b0;
                        if (!(r_skip_lf && ch == CH_LF)) begin
                            if (r_in_quotes) begin
                                if (r_pending_quote) begin
                                    n_pending_quote = 1'b0;
                                    if (ch == CH_QUOTE) begin
                                        do_append = 1'b1;
                                    end else begin
                                        n_in_quotes = 1'b0;
                                        do_unq = 1'b1;
                                    end
                                end else if (ch == CH_QUOTE) begin
                                    n_pending_quote = 1'b1;
                                end else begin
                                    do_append = 1'b1;
                                end
                            end else begin
                                do_unq = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        if (do_unq) begin
            if (ch == CH_QUOTE && r_field_len == '0) begin
                n_in_quotes = 1'b1;
            end else if (ch == r_separator) begin
                emit = 1'b1;
                emit_kind = KIND_FIELD_END;
                if (r_col_count != '1) begin
                    n_col_count = r_col_count + 1'b1;
                end
                n_field_len = '0;
            end else if (ch == CH_CR || ch == CH_LF) begin
                do_row_end = 1'b1;
                n_skip_lf = (ch == CH_CR);
            end else begin
                do_append = 1'b1;
            end
        end

        if (do_append) begin
            n_field_len = len_inc;
            emit = 1'b1;
            if (len_inc > r_max_field_chars) begin
                n_stopped = 1'b1;
                emit_kind = KIND_TOO_LONG;
            end else begin
                emit_kind = KIND_CHAR;
                emit_char = ch;
            end
        end

        if (do_row_end) begin
            emit = 1'b1;
            emit_kind = KIND_ROW_END;
            if (r_row_count != '1) begin
                n_row_count = r_row_count + 1'b1;
            end
            n_col_count = '0;
            n_field_len = '0;
            if (f_limit(n_row_count)) begin
                n_stopped = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quotes <= 1'b0;
            r_pending_quote <= 1'b0;
            r_skip_lf <= 1'b0;
            r_field_len <= '0;
            r_col_count <= '0;
            r_row_count <= '0;
            r_stopped <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_in_quotes <= n_in_quotes;
            r_pending_quote <= n_pending_quote;
            r_skip_lf <= n_skip_lf;
            r_field_len <= n_field_len;
            r_col_count <= n_col_count;
            r_row_count <= n_row_count;
            r_stopped <= n_stopped;
            if (s_acc) begin
                r_m_valid <= emit;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && emit) begin
            r_kind <= emit_kind;
            r_data_char <= emit_char;
            r_row_out <= ROW_OUT_BITS'(r_row_count);
            r_col_out <= COL_OUT_BITS'(r_col_count);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser = r_kind;
    assign o_m_tdata = {r_col_out, r_row_out, r_data_char};

`ifndef ASSERT_OFF
    a_quote_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending_quote |-> r_in_quotes)
        else $error("pending quote outside quoted field");

    a_error_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_kind == KIND_TOO_LONG || r_kind == KIND_UNCLOSED)) |-> r_stopped)
        else $error("error token without stop");

    a_restart_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tuser == ACT_RESTART) |=> !o_m_tvalid)
        else $error("restart produced a token");

    a_stopped_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && r_stopped && i_s_tuser != ACT_RESTART) |=> !o_m_tvalid)
        else $error("token while stopped");
`endif

endmodule
